// ===== sv/tbl_pkg.sv =====
// ----------------------------------------------------------------------------
// tbl_pkg
// Shared types and constants for the tent blur line pass.
// ----------------------------------------------------------------------------
package tbl_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned RadiusW = 4;
  localparam int unsigned LenW    = 13;
  localparam int unsigned CfgW    = 13;

  localparam logic REG_RADIUS   = 1'b0;
  localparam logic REG_LINE_LEN = 1'b1;

  typedef struct packed {
    logic accept;
    logic pix_init;
    logic mac;
    logic div_step;
    logic out_load;
    logic pix_next;
  } tbl_cmd_t;

  typedef struct packed {
    logic emit;
    logic mac_last;
    logic div_last;
    logic more_pix;
  } tbl_status_t;

endpackage

// ===== sv/tent_blur_line_pass.sv =====
// ----------------------------------------------------------------------------
// tent_blur_line_pass
// One pass of a clipped triangle blur along a line of 8-bit samples.
// ----------------------------------------------------------------------------
// One sample is taken per transfer, then the block is busy until every
// output it causes has been handed off. For each output the used taps (up
// to 2*radius+1) are summed one at a time in the single multiply-accumulate
// unit, then the restoring divider takes one step per dividend bit (AW = 19
// at the default radius cap) before the output waits for hand-off. A sample
// that produces no output goes from the prep state straight back to idle.
// The final sample of a line drains all remaining positions in order.
module tent_blur_line_pass
  import tbl_pkg::*;
#(
  parameter int unsigned MAX_RADIUS = 15,
  parameter int unsigned MAX_LINE   = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SampleW-1:0] blurred_o,
  output logic               last_of_line_o
);

  tbl_cmd_t    cmd;
  tbl_status_t status;

  tbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tbl_dp #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_LINE   (MAX_LINE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (sample_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .blurred_o      (blurred_o),
    .last_of_line_o (last_of_line_o)
  );

endmodule

// ===== sv/tbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbl_ctrl
// Sequencer: per input transfer, steps each due output through MAC, divide
// and output hand-off.
// ----------------------------------------------------------------------------
module tbl_ctrl
  import tbl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  tbl_status_t status_i,
  output tbl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MAC,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_PREP;
        end
      end
      S_PREP: begin
        if (status_i.emit) begin
          cmd_o.pix_init = 1'b1;
          state_d        = S_MAC;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MAC: begin
        cmd_o.mac = 1'b1;
        if (status_i.mac_last) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (status_i.more_pix) begin
            cmd_o.pix_next = 1'b1;
            state_d        = S_PREP;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/tbl_dp.sv =====
// ----------------------------------------------------------------------------
// tbl_dp
// Datapath: sample window, line position, tap MAC and restoring divider.
// ----------------------------------------------------------------------------
module tbl_dp
  import tbl_pkg::*;
#(
  parameter int unsigned MAX_RADIUS = 15,
  parameter int unsigned MAX_LINE   = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic [SampleW-1:0] sample_i,
  input  tbl_cmd_t           cmd_i,
  output tbl_status_t        status_o,
  output logic [SampleW-1:0] blurred_o,
  output logic               last_of_line_o
);

  localparam int unsigned Win = 2 * MAX_RADIUS + 1;
  localparam int unsigned IW  = $clog2(Win);
  localparam int unsigned PW  = $clog2(MAX_LINE);
  localparam int unsigned RW  = $clog2(MAX_RADIUS + 1);
  localparam int unsigned WW  = $clog2(MAX_RADIUS + 2);
  localparam int unsigned SW  = 2 * WW + 1;
  localparam int unsigned AW  = SampleW + SW;
  localparam int unsigned CW  = $clog2(AW);

  logic [RadiusW-1:0] radius_q;
  logic [LenW-1:0]    len_q;
  logic [RW-1:0]      lr_q;
  logic [PW:0]        ll_q;
  logic [PW-1:0]      pos_q, q_q, p_q, s_q;
  logic               final_q, emit_q;
  logic [SampleW-1:0] win_q [Win];
  logic [AW-1:0]      acc_q;
  logic [SW-1:0]      wsum_q;
  logic [SW:0]        rem_q;
  logic [CW-1:0]      cnt_q;
  logic [SampleW-1:0] blur_q;
  logic               last_q;

  logic [RW-1:0] r_cfg, r_eff;
  logic [PW:0]   l_cfg, l_eff;
  logic [31:0]   len32;
  logic          fin;
  logic [PW:0]   lo, hi, ph;
  logic [PW-1:0] tap_dist;
  logic [IW-1:0] idx;
  logic [WW-1:0] w;
  logic [SW:0]   rem_sh;
  logic          ge;

  always_comb begin
    if (32'(radius_q) > MAX_RADIUS) r_cfg = RW'(MAX_RADIUS);
    else                            r_cfg = RW'(radius_q);
    len32 = 32'(len_q);
    if (len32 == 32'd0)        l_cfg = (PW+1)'(1);
    else if (len32 > MAX_LINE) l_cfg = (PW+1)'(MAX_LINE);
    else                       l_cfg = (PW+1)'(len32);
    r_eff = (pos_q == '0) ? r_cfg : lr_q;
    l_eff = (pos_q == '0) ? l_cfg : ll_q;
    fin   = ({1'b0, pos_q} + (PW+1)'(1)) >= l_eff;
  end

  always_comb begin
    lo       = (p_q >= PW'(lr_q)) ? {1'b0, p_q - PW'(lr_q)} : '0;
    ph       = {1'b0, p_q} + (PW+1)'(lr_q);
    hi       = (ph > {1'b0, q_q}) ? {1'b0, q_q} : ph;
    tap_dist = (s_q >= p_q) ? s_q - p_q : p_q - s_q;
    idx      = IW'(q_q - s_q);
    w        = WW'(lr_q) - WW'(tap_dist) + WW'(1);
    rem_sh   = {rem_q[SW-1:0], acc_q[AW-1]};
    ge       = rem_sh >= {1'b0, wsum_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusW'(12);
      len_q    <= LenW'(4096);
      pos_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_RADIUS)   radius_q <= cfg_data_i[RadiusW-1:0];
      if (cfg_we_i && cfg_idx_i == REG_LINE_LEN) len_q    <= cfg_data_i[LenW-1:0];
      if (cmd_i.accept) pos_q <= fin ? '0 : pos_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      win_q[0] <= sample_i;
      for (int i = 1; i < Win; i++) win_q[i] <= win_q[i-1];
      lr_q    <= r_eff;
      ll_q    <= l_eff;
      q_q     <= pos_q;
      final_q <= fin;
      emit_q  <= fin || (pos_q >= PW'(r_eff));
      p_q     <= (pos_q >= PW'(r_eff)) ? pos_q - PW'(r_eff) : '0;
    end
    if (cmd_i.pix_next) p_q <= p_q + PW'(1);
    if (cmd_i.pix_init) begin
      s_q    <= lo[PW-1:0];
      acc_q  <= '0;
      wsum_q <= '0;
    end
    if (cmd_i.mac) begin
      acc_q  <= acc_q + AW'(win_q[idx]) * AW'(w);
      wsum_q <= wsum_q + SW'(w);
      s_q    <= s_q + PW'(1);
      rem_q  <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sh - {1'b0, wsum_q} : rem_sh;
      acc_q <= {acc_q[AW-2:0], ge};
      cnt_q <= cnt_q + CW'(1);
    end
    if (cmd_i.out_load) begin
      blur_q <= {acc_q[SampleW-2:0], ge};
      last_q <= final_q && (p_q == q_q);
    end
  end

  assign status_o.emit     = emit_q;
  assign status_o.mac_last = {1'b0, s_q} == hi;
  assign status_o.div_last = cnt_q == CW'(AW - 1);
  assign status_o.more_pix = final_q && (p_q != q_q);
  assign blurred_o         = blur_q;
  assign last_of_line_o    = last_q;

endmodule

// ===== sv/tbl_checker.sv =====
// ----------------------------------------------------------------------------
// tbl_checker
// Port-level checks for the tent blur line pass.
// ----------------------------------------------------------------------------
module tbl_checker
  import tbl_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [SampleW-1:0] blurred_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(blurred_o))
    else $error("output dropped or changed while stalled");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while result pending");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after input transfer");

endmodule

bind tent_blur_line_pass tbl_checker u_tbl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .blurred_o   (blurred_o)
);

// ===== verif/tent_blur_line_pass_tb.sv =====
// ----------------------------------------------------------------------------
// tent_blur_line_pass_tb
// Self-checking bench for the tent blur line pass. Samples are sent with
// random gaps, outputs are taken with random stalls, and a scoreboard
// predicts each blurred value and end-of-line flag from its own model of
// the clipped triangle window, the latched per-line settings and the flush.
// ----------------------------------------------------------------------------
module tent_blur_line_pass_tb;
  import tbl_pkg::*;

  localparam int unsigned WinDepth = 31;
  localparam int unsigned RadCap   = 15;
  localparam int unsigned LenCap   = 4096;

  typedef struct {
    logic [SampleW-1:0] blurred;
    logic               last;
  } blur_res_t;

  class blur_scoreboard;
    logic [SampleW-1:0] taps [WinDepth];
    int unsigned        pos;
    int unsigned        radius_reg;
    int unsigned        len_reg;
    int unsigned        cur_radius;
    int unsigned        cur_len;
    blur_res_t          pending_q [$];
    int unsigned        mismatches;

    function new();
      foreach (taps[i]) taps[i] = '0;
      pos        = 0;
      radius_reg = 12;
      len_reg    = 4096;
      cur_radius = 12;
      cur_len    = 4096;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [CfgW-1:0] val);
      if (idx == REG_RADIUS) radius_reg = val[RadiusW-1:0];
      else                   len_reg    = val;
    endfunction

    function logic [SampleW-1:0] tent_at(int p, int q, int r);
      int lo;
      int hi;
      int d;
      int unsigned acc;
      int unsigned wsum;
      lo   = (p - r < 0) ? 0 : p - r;
      hi   = (p + r > q) ? q : p + r;
      acc  = 0;
      wsum = 0;
      for (int s = lo; s <= hi; s++) begin
        d = (s > p) ? s - p : p - s;
        if (q - s < WinDepth) begin
          acc  += taps[q - s] * (r - d + 1);
          wsum += r - d + 1;
        end
      end
      return (wsum == 0) ? '0 : SampleW'(acc / wsum);
    endfunction

    function void note_sample(logic [SampleW-1:0] smp);
      int q;
      int r;
      int first;
      blur_res_t res;
      if (pos == 0) begin
        cur_radius = (radius_reg > RadCap) ? RadCap : radius_reg;
        cur_len    = (len_reg == 0) ? 1 : (len_reg > LenCap) ? LenCap : len_reg;
      end
      if (pos >= cur_len) pos = cur_len - 1;
      for (int i = WinDepth - 1; i > 0; i--) taps[i] = taps[i-1];
      taps[0] = smp;
      q     = pos;
      r     = cur_radius;
      first = q - r;
      if (pos + 1 < cur_len) begin
        if (first >= 0) begin
          res.blurred = tent_at(first, q, r);
          res.last    = 1'b0;
          pending_q.push_back(res);
        end
        pos++;
      end else begin
        if (first < 0) first = 0;
        for (int p = first; p <= q; p++) begin
          res.blurred = tent_at(p, q, r);
          res.last    = (p == q);
          pending_q.push_back(res);
        end
        pos = 0;
      end
    endfunction

    function void check_result(logic [SampleW-1:0] blurred, logic last);
      blur_res_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: blurred=%0d last=%0b", blurred, last);
        return;
      end
      exp_r = pending_q.pop_front();
      if (blurred !== exp_r.blurred || last !== exp_r.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output mismatch: exp blurred=%0d last=%0b, got blurred=%0d last=%0b",
                   exp_r.blurred, exp_r.last, blurred, last);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [SampleW-1:0] sample_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [SampleW-1:0] blurred_o;
  logic               last_of_line_o;

  blur_scoreboard sb;
  bit             gaps_on;

  tent_blur_line_pass dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .blurred_o      (blurred_o),
    .last_of_line_o (last_of_line_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  // drain side: random stalls, check each transfer
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = gaps_on ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(blurred_o, last_of_line_o);
    end
  end

  task automatic send_sample(logic [SampleW-1:0] smp);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i   = smp;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(smp);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [CfgW-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_line(logic [CfgW-1:0] rad, logic [CfgW-1:0] len);
    wait_idle();
    write_cfg(REG_RADIUS, rad);
    write_cfg(REG_LINE_LEN, len);
  endtask

  task automatic send_rand_line(int unsigned n);
    for (int i = 0; i < n; i++) send_sample(8'($urandom));
  endtask

  initial begin
    int unsigned len;
    int unsigned sent;
    sb         = new();
    gaps_on    = 1'b1;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_RADIUS;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_i   = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, zero length, short lines, mid-line update
    set_line(13'd0, 13'd4);
    send_sample(8'd0); send_sample(8'd255); send_sample(8'd255); send_sample(8'd0);
    set_line(13'd15, 13'd0);
    send_sample(8'd255);
    set_line(13'h1FFF, 13'd5);
    send_sample(8'd255); send_sample(8'd0); send_sample(8'd255);
    send_sample(8'd170); send_sample(8'd85);
    set_line(13'd2, 13'd10);
    send_sample(8'd255); send_sample(8'd255); send_sample(8'd1); send_sample(8'd128);
    wait_idle();
    write_cfg(REG_RADIUS, 13'd7);
    write_cfg(REG_LINE_LEN, 13'd3);
    send_rand_line(6);
    send_rand_line(3);

    sent = 0;
    while (sent < 120) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 20);
      set_line(13'($urandom), 13'(len));
      if ($urandom_range(0, 3) == 0) gaps_on = ~gaps_on;
      if (len == 0) len = 1;
      send_rand_line(len);
      sent += len;
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
